[hdl/gain_bucket_priority_queue_macros.svh]
// assertion macros for the gain bucket priority queue
`ifndef GAIN_BUCKET_PRIORITY_QUEUE_MACROS_SVH
`define GAIN_BUCKET_PRIORITY_QUEUE_MACROS_SVH

// check that a condition implies a consequence on the same edge
`define GBPQ_ASSERT_IMP(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("gbpq check failed");

// check that a condition implies a consequence on the next edge
`define GBPQ_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("gbpq check failed");

`endif

[hdl/gbpq_pkg.sv]
package gbpq_pkg;

    localparam int NODE_COUNT   = 1024;
    localparam int BUCKET_COUNT = 256;
    localparam int POOL_DEPTH   = 2048;

    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int BKT_W   = $clog2(BUCKET_COUNT);
    localparam int ENT_W   = $clog2(POOL_DEPTH);
    // entry pointer carries one more bit for the nil mark
    localparam int PTR_W   = ENT_W + 1;
    localparam int CNT_W   = $clog2(NODE_COUNT + 1);
    localparam int FIFO_DEPTH = 2;

    localparam logic [2:0] KIND_INSERT = 3'd0;
    localparam logic [2:0] KIND_REMOVE = 3'd1;
    localparam logic [2:0] KIND_UPDATE = 3'd2;
    localparam logic [2:0] KIND_POP    = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [2:0] ADDR_LOWEST  = 3'd0;
    localparam logic [2:0] ADDR_HIGHEST = 3'd4;

    typedef struct packed {
        logic [2:0]         kind;
        logic [9:0]         node;
        logic signed [15:0] gain_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [9:0]         popped_node;
        logic signed [15:0] popped_gain;
        logic [10:0]        live_count;
    } out_item_t;

    // classified operation handed from the front part to the back part
    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_UPDATE = 3'd2,
        OP_POP    = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_IGNORE = 3'd5
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [NODE_W-1:0] node;
        logic [BKT_W-1:0]  bucket;
    } cmd_t;

endpackage

[hdl/gain_bucket_priority_queue.sv]
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+---------------------------
// items    | in        | push / full         | in_item  (kind, node, gain_in)
// results  | out       | pop / empty         | out_item (status, node, gain, count)
// config   | in        | psel/penable/pready | lowest_gain @0, highest_gain @4
//
// insert and update do a presence check then an insert step, remove and ignored items the check only
// pop max walks down from the top bucket past empty buckets and stale entries
// reset and a write to either config register start a clearing pass over the pool
// a clear item runs the same clearing pass before its result shows
// a waiting result holds the back part until it is popped
// a two deep command queue lets items enter while the back part works
module gain_bucket_priority_queue
    import gbpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    in_item,
    output logic        empty,
    input  logic        pop,
    output out_item_t   out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic signed [15:0] lowest_reg;
    logic [14:0]        highest_reg;
    logic               cfg_wr, cfg_clear;
    logic               cmd_valid, cmd_take, busy, res_valid;
    cmd_t               cmd;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    // a write to either register empties the queue
    assign cfg_clear = cfg_wr && (paddr == ADDR_LOWEST || paddr == ADDR_HIGHEST);

    always_comb
    begin
        case (paddr)
            ADDR_LOWEST:  prdata = 32'(signed'(lowest_reg));
            ADDR_HIGHEST: prdata = 32'(highest_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg  <= -16'sd128;
            highest_reg <= 15'd127;
        end
        else if (cfg_wr)
        begin
            if (paddr == ADDR_LOWEST)
            begin
                lowest_reg <= pwdata[15:0];
            end
            if (paddr == ADDR_HIGHEST)
            begin
                highest_reg <= pwdata[14:0];
            end
        end
    end

    gbpq_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .in_item      (in_item),
        .lowest_gain  (lowest_reg),
        .highest_gain (highest_reg),
        .flush        (cfg_clear && !busy),
        .cmd_valid    (cmd_valid),
        .cmd_take     (cmd_take),
        .cmd          (cmd)
    );

    gbpq_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_take    (cmd_take),
        .cmd         (cmd),
        .lowest_gain (lowest_reg),
        .cfg_clear   (cfg_clear),
        .busy        (busy),
        .res_valid   (res_valid),
        .res_take    (pop),
        .res         (out_item)
    );

    assign empty = !res_valid;

endmodule

[hdl/gbpq_front.sv]
module gbpq_front
    import gbpq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  in_item_t           in_item,
    input  logic signed [15:0] lowest_gain,
    input  logic [14:0]        highest_gain,
    input  logic               flush,
    output logic               cmd_valid,
    input  logic               cmd_take,
    output cmd_t               cmd
);

    cmd_t                    fifo_mem [FIFO_DEPTH];
    logic                    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0]              fill_reg, fill_next;
    cmd_t                    cls;
    logic signed [17:0]      hi_lim, g, idx;
    logic                    acc;

    // clamp gain into the configured range and classify the item
    always_comb
    begin
        hi_lim = 18'(lowest_gain) + 18'(BUCKET_COUNT - 1);
        if (18'(signed'({1'b0, highest_gain})) < hi_lim)
        begin
            hi_lim = 18'(signed'({1'b0, highest_gain}));
        end
        g = 18'(in_item.gain_in);
        if (g > hi_lim)
        begin
            g = hi_lim;
        end
        if (g < 18'(lowest_gain))
        begin
            g = 18'(lowest_gain);
        end
        idx = g - 18'(lowest_gain);
        cls.node   = in_item.node[NODE_W-1:0];
        cls.bucket = (idx < 0 || idx >= 18'(BUCKET_COUNT)) ? '0 : idx[BKT_W-1:0];
        case (in_item.kind)
            KIND_INSERT: cls.op = OP_INSERT;
            KIND_REMOVE: cls.op = OP_REMOVE;
            KIND_UPDATE: cls.op = OP_UPDATE;
            KIND_POP:    cls.op = OP_POP;
            KIND_CLEAR:  cls.op = OP_CLEAR;
            default:     cls.op = OP_IGNORE;
        endcase
        if ((cls.op == OP_INSERT || cls.op == OP_REMOVE || cls.op == OP_UPDATE)
            && 32'(in_item.node) >= NODE_COUNT)
        begin
            cls.op = OP_IGNORE;
        end
    end

    assign full      = (fill_reg == 2'(FIFO_DEPTH));
    assign acc       = push && !full;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + 1'(acc);
        rd_ptr_next = rd_ptr_reg + 1'(cmd_take);
        fill_next   = fill_reg + 2'(acc) - 2'(cmd_take);
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            fifo_mem[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else if (flush)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[hdl/gbpq_back.sv]
module gbpq_back
    import gbpq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_take,
    input  cmd_t               cmd,
    input  logic signed [15:0] lowest_gain,
    input  logic               cfg_clear,
    output logic               busy,
    output logic               res_valid,
    input  logic               res_take,
    output out_item_t          res
);

    typedef enum logic [8:0] {
        S_CLR   = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_PRES  = 9'b000000100,
        S_INS0  = 9'b000001000,
        S_INS1  = 9'b000010000,
        S_POPH  = 9'b000100000,
        S_POPE  = 9'b001000000,
        S_POPC  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    // memories
    logic              pres_mem  [NODE_COUNT];
    logic [PTR_W-1:0]  head_mem  [BUCKET_COUNT];
    logic [NODE_W-1:0] pnode_mem [POOL_DEPTH];
    logic [PTR_W-1:0]  pnext_mem [POOL_DEPTH];

    state_t            state_reg, state_next;
    cmd_t              cmd_reg;
    logic [ENT_W:0]    clr_reg;
    logic [PTR_W-1:0]  free_reg;
    logic [BKT_W:0]    top_reg;    // msb set means below bucket zero
    logic [CNT_W-1:0]  cnt_reg;
    logic              res_valid_reg;
    out_item_t         res_reg;
    logic              pres_rd_reg;
    logic [PTR_W-1:0]  head_rd_reg, e_reg;
    logic [NODE_W-1:0] pnode_rd_reg;
    logic [PTR_W-1:0]  pnext_rd_reg, fnext_rd_reg;
    logic [1:0]        st_reg;
    logic [NODE_W-1:0] pn_reg;
    logic signed [15:0] pg_reg;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign cmd_take  = (state_reg == S_IDLE) && cmd_valid && !cfg_clear;
    assign busy      = (state_reg != S_IDLE) || cmd_valid;

    always_ff @(posedge clk)
    begin
        // clear sweep covers presence flags, buckets and pool
        if (state_reg == S_CLR)
        begin
            if (clr_reg < (ENT_W+1)'(NODE_COUNT))
            begin
                pres_mem[clr_reg[NODE_W-1:0]] <= 1'b0;
            end
            if (clr_reg < (ENT_W+1)'(BUCKET_COUNT))
            begin
                head_mem[clr_reg[BKT_W-1:0]] <= PTR_W'(POOL_DEPTH);
            end
            pnext_mem[clr_reg[ENT_W-1:0]] <= PTR_W'(clr_reg) + 1'b1;
        end
        else
        begin
            if (state_reg == S_IDLE && cmd_take)
            begin
                cmd_reg     <= cmd;
                pres_rd_reg <= pres_mem[cmd.node];
                head_rd_reg <= head_mem[cmd.bucket];
            end
            if (state_reg == S_PRES)
            begin
                fnext_rd_reg <= pnext_mem[free_reg[ENT_W-1:0]];
                if (cmd_reg.op == OP_UPDATE && pres_rd_reg)
                begin
                    pres_mem[cmd_reg.node] <= 1'b0;
                end
                if (cmd_reg.op == OP_REMOVE && pres_rd_reg)
                begin
                    pres_mem[cmd_reg.node] <= 1'b0;
                end
            end
            if (state_reg == S_INS1)
            begin
                pnode_mem[free_reg[ENT_W-1:0]] <= cmd_reg.node;
                pnext_mem[free_reg[ENT_W-1:0]] <= head_rd_reg;
                head_mem[cmd_reg.bucket]       <= free_reg;
                pres_mem[cmd_reg.node]         <= 1'b1;
            end
            if (state_reg == S_POPH)
            begin
                head_rd_reg <= head_mem[top_reg[BKT_W-1:0]];
            end
            if (state_reg == S_POPE)
            begin
                e_reg        <= head_rd_reg;
                pnode_rd_reg <= pnode_mem[head_rd_reg[ENT_W-1:0]];
                pnext_rd_reg <= pnext_mem[head_rd_reg[ENT_W-1:0]];
            end
            if (state_reg == S_INS0)
            begin
                pres_rd_reg <= pres_mem[pnode_rd_reg];
            end
            if (state_reg == S_POPC)
            begin
                head_mem[top_reg[BKT_W-1:0]]  <= pnext_rd_reg;
                pnext_mem[e_reg[ENT_W-1:0]]   <= free_reg;
                head_rd_reg                   <= pnext_rd_reg;
                if (pres_rd_reg)
                begin
                    pres_mem[pnode_rd_reg] <= 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:  state_next = (clr_reg == (ENT_W+1)'(POOL_DEPTH - 1)) ? S_IDLE : S_CLR;
            S_IDLE: state_next = cmd_take ? S_PRES : S_IDLE;
            default: state_next = state_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            free_reg      <= '0;
            top_reg       <= '1;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
            st_reg        <= ST_DONE;
        end
        else
        begin
            if (res_valid_reg && res_take && !(state_reg == S_OUT && !cfg_clear))
            begin
                res_valid_reg <= 1'b0;
            end
            if (cfg_clear)
            begin
                state_reg <= S_CLR;
                clr_reg   <= '0;
                free_reg  <= '0;
                top_reg   <= '1;
                cnt_reg   <= '0;
                st_reg    <= ST_DONE;
            end
            else
            begin
                case (state_reg)
                    S_CLR:
                    begin
                        clr_reg <= clr_reg + 1'b1;
                        if (clr_reg == (ENT_W+1)'(POOL_DEPTH - 1))
                        begin
                            state_reg <= (cmd_reg.op == OP_CLEAR && st_reg == ST_EMPTY)
                                         ? S_OUT : S_IDLE;
                        end
                    end
                    S_IDLE:
                    begin
                        state_reg <= state_next;
                    end
                    S_PRES:
                    begin
                        pn_reg <= '0;
                        pg_reg <= '0;
                        case (cmd_reg.op)
                            OP_REMOVE:
                            begin
                                st_reg <= pres_rd_reg ? ST_DONE : ST_IGNORED;
                                if (pres_rd_reg)
                                begin
                                    cnt_reg <= cnt_reg - 1'b1;
                                end
                                state_reg <= S_OUT;
                            end
                            OP_INSERT, OP_UPDATE:
                            begin
                                if (cmd_reg.op == OP_INSERT && pres_rd_reg)
                                begin
                                    st_reg    <= ST_IGNORED;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    if (pres_rd_reg)
                                    begin
                                        cnt_reg <= cnt_reg - 1'b1;
                                    end
                                    if (free_reg[ENT_W])
                                    begin
                                        st_reg    <= ST_FULL;
                                        state_reg <= S_OUT;
                                    end
                                    else
                                    begin
                                        st_reg    <= ST_DONE;
                                        state_reg <= S_INS1;
                                    end
                                end
                            end
                            OP_POP:
                            begin
                                if (cnt_reg == '0)
                                begin
                                    st_reg    <= ST_EMPTY;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_POPH;
                                end
                            end
                            OP_CLEAR:
                            begin
                                // sweep then report; marked by status code
                                clr_reg   <= '0;
                                free_reg  <= '0;
                                top_reg   <= '1;
                                cnt_reg   <= '0;
                                state_reg <= S_CLR;
                                st_reg    <= ST_EMPTY;
                            end
                            default:
                            begin
                                st_reg    <= ST_IGNORED;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                    S_INS1:
                    begin
                        free_reg <= fnext_rd_reg;
                        cnt_reg  <= cnt_reg + 1'b1;
                        if (top_reg[BKT_W] || cmd_reg.bucket > top_reg[BKT_W-1:0])
                        begin
                            top_reg <= {1'b0, cmd_reg.bucket};
                        end
                        state_reg <= S_OUT;
                    end
                    S_POPH:
                    begin
                        if (top_reg[BKT_W])
                        begin
                            st_reg    <= ST_EMPTY;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_POPE;
                        end
                    end
                    S_POPE:
                    begin
                        if (head_rd_reg[ENT_W])
                        begin
                            top_reg   <= top_reg - 1'b1;
                            state_reg <= S_POPH;
                        end
                        else
                        begin
                            state_reg <= S_INS0;
                        end
                    end
                    S_INS0:
                    begin
                        state_reg <= S_POPC;
                    end
                    S_POPC:
                    begin
                        free_reg <= e_reg;
                        if (pres_rd_reg)
                        begin
                            cnt_reg   <= cnt_reg - 1'b1;
                            st_reg    <= ST_DONE;
                            pn_reg    <= pnode_rd_reg;
                            pg_reg    <= lowest_gain + 16'(top_reg[BKT_W-1:0]);
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_POPE;
                        end
                    end
                    S_OUT:
                    begin
                        if (!res_valid_reg || res_take)
                        begin
                            res_valid_reg       <= 1'b1;
                            res_reg.status      <= (cmd_reg.op == OP_CLEAR) ? ST_DONE : st_reg;
                            res_reg.live_count  <= 11'(cnt_reg);
                            res_reg.popped_node <= pn_reg;
                            res_reg.popped_gain <= pg_reg;
                            state_reg           <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

[hdl/gbpq_checker.sv]
`include "gain_bucket_priority_queue_macros.svh"

module gbpq_checker
    import gbpq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      push,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input out_item_t out_item
);

    `GBPQ_ASSERT_NEXT(a_res_hold, empty == 1'b0 && pop == 1'b0, empty == 1'b0)
    `GBPQ_ASSERT_IMP(a_pop_node_zero, empty == 1'b0 && out_item.status != ST_DONE,
        out_item.popped_node == '0)
    `GBPQ_ASSERT_IMP(a_count_range, empty == 1'b0, out_item.live_count <= 11'(NODE_COUNT))
    `GBPQ_ASSERT_IMP(a_ctrl_known, 1'b1, !$isunknown({push, full, empty, pop}))

endmodule

bind gain_bucket_priority_queue gbpq_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);
